// ===== design/htlm_pkg.sv =====
package htlm_pkg;

    // Default sizing
    localparam int MAX_NODES_DEF = 64;
    localparam int USER_BITS_DEF = 16;

    // Fixed field widths
    localparam int OPC_W  = 2;
    localparam int NODE_W = 6;
    localparam int USER_W = 16;
    localparam int CFG_W  = 7;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_LOCK    = 2'd0;
    localparam logic [OPC_W-1:0] OP_UNLOCK  = 2'd1;
    localparam logic [OPC_W-1:0] OP_UPGRADE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_CHILDREN   = 1'b1;

    // Datapath commands, one per cycle
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_CLR,
        CMD_RD_TGT,
        CMD_WR_UNLOCK_TGT,
        CMD_WR_LOCK,
        CMD_WALK_TGT,
        CMD_DIV_START,
        CMD_DIV_STEP,
        CMD_WALK_RD,
        CMD_WR_INC,
        CMD_WR_DEC,
        CMD_SCAN_INIT,
        CMD_SCAN_LEVEL,
        CMD_SCAN_RD,
        CMD_SCAN_NEXT,
        CMD_SCAN_UNLOCK
    } t_cmd;

    // Datapath status towards the controller
    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic             in_range;
        logic             flag;
        logic             owner_match;
        logic             cnt_zero;
        logic             cur_zero;
        logic             div_last;
        logic             j_end;
        logic             j_above;
        logic             j_in;
        logic             clr_last;
    } t_status;

endpackage

// ===== design/htlm_req_if.sv =====
interface htlm_req_if import htlm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [NODE_W-1:0] node_index;
    logic [USER_W-1:0] user_id;

    modport source (output valid, opcode, node_index, user_id, input ready);
    modport sink   (input valid, opcode, node_index, user_id, output ready);
endinterface

// ===== design/htlm_rsp_if.sv =====
interface htlm_rsp_if;
    logic valid;
    logic ready;
    logic granted;

    modport source (output valid, granted, input ready);
    modport sink   (input valid, granted, output ready);
endinterface

// ===== design/htlm_dp.sv =====
module htlm_dp import htlm_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int USER_BITS = USER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [OPC_W-1:0]  i_opcode,
    input  logic [NODE_W-1:0] i_node_index,
    input  logic [USER_W-1:0] i_user_id,
    output t_status           o_status
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam int RNG_W = IDX_W + 7;
    localparam int DC_W  = $clog2(IDX_W + 1);

    typedef struct packed {
        logic                 flag;
        logic [USER_BITS-1:0] owner;
        logic [IDX_W-1:0]     count;
    } t_entry;

    // Lock table
    t_entry r_mem [MAX_NODES];
    t_entry r_rd;

    logic [6:0]           r_node_count;
    logic [5:0]           r_children;
    logic [OPC_W-1:0]     r_op;
    logic [NODE_W-1:0]    r_node_raw;
    logic [USER_BITS-1:0] r_user;
    logic [IDX_W-1:0]     r_cur;
    logic [IDX_W-1:0]     r_quo;
    logic [5:0]           r_rem;
    logic [DC_W-1:0]      r_dcnt;
    logic [CNT_W-1:0]     r_j;
    logic [RNG_W-1:0]     r_lo;
    logic [RNG_W-1:0]     r_hi;

    logic [5:0]       m_eff;
    logic [CMP_W-1:0] live;
    logic [CMP_W-1:0] node_ext;
    logic [IDX_W-1:0] node_addr;
    logic [CMP_W-1:0] j_ext;
    logic [RNG_W-1:0] j_rng;
    logic [6:0]       rem_sh;
    logic             q_bit;
    logic [RNG_W+5:0] base_prod;
    logic [RNG_W+5:0] lo_prod;
    logic [RNG_W+5:0] hi_prod;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] cnt_inc;
    logic [IDX_W-1:0] cnt_dec;

    // Tree geometry
    assign m_eff     = (r_children == 6'd0) ? 6'd1 : r_children;
    assign live      = (CMP_W'(r_node_count) > CMP_W'(MAX_NODES)) ?
                       CMP_W'(MAX_NODES) : CMP_W'(r_node_count);
    assign node_ext  = CMP_W'(r_node_raw);
    assign node_addr = node_ext[IDX_W-1:0];
    assign j_ext     = CMP_W'(r_j);
    assign j_rng     = RNG_W'(r_j);

    // Parent divider step: one quotient bit a cycle
    assign rem_sh = {r_rem, r_quo[IDX_W-1]};
    assign q_bit  = (rem_sh >= 7'(m_eff));

    // Descendant range of the next level
    assign base_prod = (RNG_W + 6)'(node_addr) * (RNG_W + 6)'(m_eff);
    assign lo_prod   = (RNG_W + 6)'(r_lo) * (RNG_W + 6)'(m_eff);
    assign hi_prod   = (RNG_W + 6)'(r_hi) * (RNG_W + 6)'(m_eff);

    // Saturating count updates
    assign cnt_inc = (r_rd.count < IDX_W'(MAX_NODES - 1)) ? r_rd.count + 1'b1 : r_rd.count;
    assign cnt_dec = (r_rd.count != '0) ? r_rd.count - 1'b1 : r_rd.count;

    // Decode memory accesses
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cur;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = r_cur;
        case (i_cmd)
            CMD_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_j[IDX_W-1:0];
            end
            CMD_RD_TGT: begin
                rd_en   = 1'b1;
                rd_addr = node_addr;
            end
            CMD_WR_UNLOCK_TGT: begin
                wr_en         = 1'b1;
                wr_addr       = node_addr;
                wr_data.count = r_rd.count;
            end
            CMD_WR_LOCK: begin
                wr_en         = 1'b1;
                wr_addr       = node_addr;
                wr_data.flag  = 1'b1;
                wr_data.owner = r_user;
            end
            CMD_WALK_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_quo;
            end
            CMD_WR_INC: begin
                wr_en         = 1'b1;
                wr_data       = r_rd;
                wr_data.count = cnt_inc;
            end
            CMD_WR_DEC: begin
                wr_en         = 1'b1;
                wr_data       = r_rd;
                wr_data.count = cnt_dec;
            end
            CMD_SCAN_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_j[IDX_W-1:0];
            end
            CMD_SCAN_UNLOCK: begin
                wr_en         = 1'b1;
                wr_addr       = r_j[IDX_W-1:0];
                wr_data.count = r_rd.count;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Table port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 7'd1;
            r_children   <= 6'd2;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_NODE_COUNT) begin
                r_node_count <= i_cfg_data;
            end else begin
                r_children <= i_cfg_data[5:0];
            end
        end
    end

    // Scan and clear pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j <= '0;
        end else begin
            case (i_cmd)
                CMD_CLR, CMD_SCAN_NEXT, CMD_SCAN_UNLOCK: r_j <= r_j + 1'b1;
                CMD_SCAN_INIT:                           r_j <= '0;
                default:                                 r_j <= r_j;
            endcase
        end
    end

    // Request, walk, divider and range registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_ACCEPT: begin
                r_op       <= i_opcode;
                r_node_raw <= i_node_index;
                r_user     <= USER_BITS'(i_user_id);
            end
            CMD_WALK_TGT, CMD_WR_UNLOCK_TGT, CMD_WR_LOCK: begin
                r_cur <= node_addr;
            end
            CMD_DIV_START: begin
                r_quo  <= r_cur - 1'b1;
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            CMD_DIV_STEP: begin
                r_quo  <= IDX_W'({r_quo, q_bit});
                r_rem  <= q_bit ? 6'(rem_sh - 7'(m_eff)) : rem_sh[5:0];
                r_dcnt <= r_dcnt + 1'b1;
            end
            CMD_WALK_RD: begin
                r_cur <= r_quo;
            end
            CMD_SCAN_INIT: begin
                r_lo <= RNG_W'(base_prod + 1'b1);
                r_hi <= RNG_W'(base_prod + (RNG_W + 6)'(m_eff));
            end
            CMD_SCAN_LEVEL: begin
                r_lo <= RNG_W'(lo_prod + 1'b1);
                r_hi <= RNG_W'(hi_prod + (RNG_W + 6)'(m_eff));
            end
            CMD_SCAN_UNLOCK: begin
                r_cur <= r_j[IDX_W-1:0];
            end
            default: begin
                r_cur <= r_cur;
            end
        endcase
    end

    // Status
    assign o_status.op          = r_op;
    assign o_status.in_range    = (node_ext < live);
    assign o_status.flag        = r_rd.flag;
    assign o_status.owner_match = (r_rd.owner == r_user);
    assign o_status.cnt_zero    = (r_rd.count == '0);
    assign o_status.cur_zero    = (r_cur == '0);
    assign o_status.div_last    = (r_dcnt == DC_W'(IDX_W - 1));
    assign o_status.j_end       = (j_ext >= live);
    assign o_status.j_above     = (j_rng > r_hi);
    assign o_status.j_in        = (j_rng >= r_lo);
    assign o_status.clr_last    = (r_j == CNT_W'(MAX_NODES - 1));

endmodule

// ===== design/htlm_ctrl.sv =====
module htlm_ctrl import htlm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    input  logic    i_req_valid,
    input  logic    i_rsp_ready,
    output logic    o_req_ready,
    output logic    o_rsp_valid,
    output logic    o_rsp_granted,
    output t_cmd    o_cmd
);

    typedef enum logic [11:0] {
        S_CLR       = 12'b0000_0000_0001,
        S_IDLE      = 12'b0000_0000_0010,
        S_CHECK     = 12'b0000_0000_0100,
        S_EVAL_TGT  = 12'b0000_0000_1000,
        S_WALK_TEST = 12'b0000_0001_0000,
        S_WALK_DIV  = 12'b0000_0010_0000,
        S_WALK_RD   = 12'b0000_0100_0000,
        S_WALK_ACT  = 12'b0000_1000_0000,
        S_SCAN_ADV  = 12'b0001_0000_0000,
        S_SCAN_CHK  = 12'b0010_0000_0000,
        S_DONE      = 12'b0100_0000_0000,
        S_SPARE     = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        WALK_CHECK,
        WALK_INC,
        WALK_DEC
    } t_walk_mode;

    t_state     r_state, n_state;
    t_walk_mode r_mode, n_mode;
    logic       r_lock, n_lock;
    logic       r_pass2, n_pass2;
    logic       r_res, n_res;
    logic       r_out_valid, n_out_valid;
    logic       r_out_granted, n_out_granted;
    logic       op_bad;

    assign op_bad = (i_status.op != OP_LOCK) && (i_status.op != OP_UNLOCK) &&
                    (i_status.op != OP_UPGRADE);

    // Next state and command
    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_lock        = r_lock;
        n_pass2       = r_pass2;
        n_res         = r_res;
        n_out_valid   = r_out_valid && !i_rsp_ready;
        n_out_granted = r_out_granted;
        o_cmd         = CMD_NONE;
        o_req_ready   = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd = CMD_CLR;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd   = CMD_ACCEPT;
                    n_lock  = 1'b0;
                    n_pass2 = 1'b0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.in_range || op_bad) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = CMD_RD_TGT;
                    n_lock  = r_lock || (i_status.op == OP_LOCK);
                    n_state = S_EVAL_TGT;
                end
            end
            S_EVAL_TGT: begin
                if (r_lock) begin
                    if (i_status.flag || !i_status.cnt_zero) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        o_cmd   = CMD_WALK_TGT;
                        n_mode  = WALK_CHECK;
                        n_state = S_WALK_TEST;
                    end
                end else if (i_status.op == OP_UNLOCK) begin
                    if (!i_status.flag || !i_status.owner_match) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        o_cmd   = CMD_WR_UNLOCK_TGT;
                        n_mode  = WALK_DEC;
                        n_state = S_WALK_TEST;
                    end
                end else begin
                    if (i_status.flag || i_status.cnt_zero) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        o_cmd   = CMD_SCAN_INIT;
                        n_state = S_SCAN_ADV;
                    end
                end
            end
            // Climb one ancestor per pass; at the root, end this walk
            S_WALK_TEST: begin
                if (i_status.cur_zero) begin
                    case (r_mode)
                        WALK_CHECK: begin
                            o_cmd   = CMD_WR_LOCK;
                            n_mode  = WALK_INC;
                            n_state = S_WALK_TEST;
                        end
                        WALK_INC: begin
                            n_res   = 1'b1;
                            n_state = S_DONE;
                        end
                        default: begin
                            if (i_status.op == OP_UNLOCK) begin
                                n_res   = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_SCAN_ADV;
                            end
                        end
                    endcase
                end else begin
                    o_cmd   = CMD_DIV_START;
                    n_state = S_WALK_DIV;
                end
            end
            S_WALK_DIV: begin
                o_cmd = CMD_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                o_cmd   = CMD_WALK_RD;
                n_state = S_WALK_ACT;
            end
            S_WALK_ACT: begin
                case (r_mode)
                    WALK_CHECK: begin
                        if (i_status.flag) begin
                            n_res   = 1'b0;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_WALK_TEST;
                        end
                    end
                    WALK_INC: begin
                        o_cmd   = CMD_WR_INC;
                        n_state = S_WALK_TEST;
                    end
                    default: begin
                        o_cmd   = CMD_WR_DEC;
                        n_state = S_WALK_TEST;
                    end
                endcase
            end
            // Sweep the nodes level by level over the target's subtree
            S_SCAN_ADV: begin
                if (i_status.j_end) begin
                    if (!r_pass2) begin
                        o_cmd   = CMD_SCAN_INIT;
                        n_pass2 = 1'b1;
                    end else begin
                        n_lock  = 1'b1;
                        n_state = S_CHECK;
                    end
                end else if (i_status.j_above) begin
                    o_cmd = CMD_SCAN_LEVEL;
                end else begin
                    o_cmd   = CMD_SCAN_RD;
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_status.j_in && i_status.flag) begin
                    if (!r_pass2) begin
                        if (!i_status.owner_match) begin
                            n_res   = 1'b0;
                            n_state = S_DONE;
                        end else begin
                            o_cmd   = CMD_SCAN_NEXT;
                            n_state = S_SCAN_ADV;
                        end
                    end else begin
                        o_cmd   = CMD_SCAN_UNLOCK;
                        n_mode  = WALK_DEC;
                        n_state = S_WALK_TEST;
                    end
                end else begin
                    o_cmd   = CMD_SCAN_NEXT;
                    n_state = S_SCAN_ADV;
                end
            end
            // Hand the answer to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_granted = r_res;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_mode      <= WALK_CHECK;
            r_lock      <= 1'b0;
            r_pass2     <= 1'b0;
            r_res       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_lock      <= n_lock;
            r_pass2     <= n_pass2;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_granted <= n_out_granted;
    end

    assign o_rsp_valid   = r_out_valid;
    assign o_rsp_granted = r_out_granted;

endmodule

// ===== design/hierarchical_tree_lock_manager.sv =====
// A walk from a node at depth d climbs d ancestors; each step runs the parent divider, which
// resolves one quotient bit a cycle. Unlock takes one walk; lock takes two (a check walk, then
// a count walk). Upgrade adds two sweeps over the nodes plus one ancestor walk per release.
// One request at a time; the next is taken once the previous answer sits in the output register.
// Reset: synchronous, active low; then a clearing pass writes every table entry before the first beat.
module hierarchical_tree_lock_manager import htlm_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int USER_BITS = USER_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    htlm_req_if.sink         i_req,
    htlm_rsp_if.source       o_rsp,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // Sequencer
    htlm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_status      (status),
        .i_req_valid   (i_req.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_req_ready   (i_req.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_rsp_granted (o_rsp.granted),
        .o_cmd         (cmd)
    );

    // Lock table and arithmetic
    htlm_dp #(
        .MAX_NODES (MAX_NODES),
        .USER_BITS (USER_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_opcode     (i_req.opcode),
        .i_node_index (i_req.node_index),
        .i_user_id    (i_req.user_id),
        .o_status     (status)
    );

endmodule
